// ===== hw/rtl/sexpr_token_lexer_assert.svh =====
// Assertion macros shared by the lexer RTL modules.
`ifndef SEXPR_TOKEN_LEXER_ASSERT_SVH
`define SEXPR_TOKEN_LEXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SXL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lexer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SXL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lexer assertion failed");

`endif

// ===== hw/rtl/sxl_pkg.sv =====
// Types and constants shared by the lexer modules.
package sxl_pkg;

    localparam int KIND_W = 4;
    localparam int OFF_W  = 32;
    localparam int LEN_W  = 16;
    localparam int VAL_W  = 64;
    localparam int WID_W  = 16;
    localparam int MODE_W = 4;

    localparam logic [LEN_W-1:0] LEN_CAP = 16'hFFFF;
    localparam logic [WID_W-1:0] WID_CAP = 16'hFFFF;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Token kinds.
    localparam logic [KIND_W-1:0] K_LPAREN  = 4'd0;
    localparam logic [KIND_W-1:0] K_RPAREN  = 4'd1;
    localparam logic [KIND_W-1:0] K_SYMBOL  = 4'd2;
    localparam logic [KIND_W-1:0] K_NUMERAL = 4'd3;
    localparam logic [KIND_W-1:0] K_BITVEC  = 4'd4;
    localparam logic [KIND_W-1:0] K_STRING  = 4'd5;
    localparam logic [KIND_W-1:0] K_KEYWORD = 4'd6;
    localparam logic [KIND_W-1:0] K_EOF     = 4'd7;
    localparam logic [KIND_W-1:0] K_ERROR   = 4'd8;

    // Lexer modes.
    localparam logic [MODE_W-1:0] M_IDLE    = 4'd0;
    localparam logic [MODE_W-1:0] M_COMMENT = 4'd1;
    localparam logic [MODE_W-1:0] M_SYM     = 4'd2;
    localparam logic [MODE_W-1:0] M_KEY     = 4'd3;
    localparam logic [MODE_W-1:0] M_NUM     = 4'd4;
    localparam logic [MODE_W-1:0] M_HASH    = 4'd5;
    localparam logic [MODE_W-1:0] M_BIN     = 4'd6;
    localparam logic [MODE_W-1:0] M_HEX     = 4'd7;
    localparam logic [MODE_W-1:0] M_STR     = 4'd8;
    localparam logic [MODE_W-1:0] M_STRQ    = 4'd9;
    localparam logic [MODE_W-1:0] M_QSYM    = 4'd10;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OFF_W-1:0]  start;
        logic [LEN_W-1:0]  len;
        logic [VAL_W-1:0]  value;
        logic [WID_W-1:0]  width;
    } t_tok;

    // Tokens caused by one input byte; tok1 is used only when two is set.
    typedef struct packed {
        logic two;
        t_tok tok0;
        t_tok tok1;
    } t_entry;

endpackage

// ===== hw/rtl/sexpr_token_lexer.sv =====
// Top level of the byte-serial S-expression token lexer.
// Input stream: one request per byte. tdata carries the text byte and tuser[0]
// marks end of buffer (tdata is then ignored). Each request yields zero, one or
// two token requests on the output stream; tlast marks the last token of a byte.
// A token gives kind, start offset, length, numeric value and bit-vector width.
// End of buffer flushes any open token (error if a string, a quoted symbol, a
// lone # or a bit-vector prefix without digits is open), emits EOF at the end
// offset and restarts offsets at zero. The input takes one byte per cycle while
// the queue has room; the output moves one token per cycle while tready is high,
// so a byte that closes one token and opens another needs a second transfer. A
// token is written to the queue as the scan state register updates and is then
// loaded into the output register. The scanner, a four-entry queue and the
// output register are separate, so the input flows on while the output is stalled
// until the queue fills; tready on the input then drops until tokens are taken.
// Synchronous active-low reset empties the queue, drops output valid and puts
// the scanner between tokens at offset zero.
module sexpr_token_lexer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] text_byte
    input  logic [0:0]   i_s_tuser,   // [0] action (end of buffer)
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [135:0] o_m_tdata,   // [3:0] kind, [35:4] start_offset,
                                      // [51:36] token_length, [115:52] number_value,
                                      // [131:116] literal_width, [135:132] zero
    output logic         o_m_tlast
);
    import sxl_pkg::*;

    logic   q_full, q_valid, q_push, q_pop;
    t_entry f_entry, q_head;
    t_tok   out_tok;

    sxl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_action (i_s_tuser[0]),
        .i_byte   (i_s_tdata),
        .i_full   (q_full),
        .o_ready  (o_s_tready),
        .o_push   (q_push),
        .o_entry  (f_entry)
    );

    sxl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (f_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    sxl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_head  (q_head),
        .i_ready (i_m_tready),
        .o_pop   (q_pop),
        .o_valid (o_m_tvalid),
        .o_last  (o_m_tlast),
        .o_tok   (out_tok)
    );

    assign o_m_tdata = {4'b0000, out_tok.width, out_tok.value, out_tok.len,
                        out_tok.start, out_tok.kind};

endmodule

// ===== hw/rtl/sxl_front.sv =====
// Lexer front end: takes one byte per cycle while the queue is not full, updates the scan state, forms tokens.
`include "sexpr_token_lexer_assert.svh"
module sxl_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_action,
    input  logic [7:0]     i_byte,
    input  logic           i_full,
    output logic           o_ready,
    output logic           o_push,
    output sxl_pkg::t_entry o_entry
);
    import sxl_pkg::*;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LPAR = 8'h28;
    localparam logic [7:0] CH_RPAR = 8'h29;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_COL  = 8'h3A;
    localparam logic [7:0] CH_BAR  = 8'h7C;

    logic [MODE_W-1:0] r_mode, n_mode;
    logic [OFF_W-1:0]  r_pos, n_pos;
    logic [OFF_W-1:0]  r_start, n_start;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [WID_W-1:0]  r_bits, n_bits;

    logic        accept;
    logic        a_vld, b_vld, relex, beg, beg_num;
    logic [MODE_W-1:0] beg_mode;
    t_tok        a_tok, b_tok;
    logic [LEN_W-1:0] grown;
    logic [3:0]  hex_digit;
    logic        c_space, c_delim, c_digit, c_hex;

    function automatic logic [WID_W-1:0] add_bits(input logic [WID_W-1:0] b,
                                                   input logic [WID_W-1:0] k);
        logic [WID_W-1:0] room;
        room = WID_CAP - k;
        return (b > room) ? WID_CAP : b + k;
    endfunction

    assign accept  = i_valid && o_ready;
    assign o_ready = !i_full;

    assign c_space = (i_byte == 8'h20) || (i_byte >= 8'h09 && i_byte <= 8'h0D);
    assign c_delim = c_space || i_byte == CH_NUL || i_byte == CH_LPAR ||
                     i_byte == CH_RPAR || i_byte == CH_SEMI || i_byte == CH_DQ;
    assign c_digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign c_hex   = c_digit || (i_byte >= 8'h61 && i_byte <= 8'h66) ||
                     (i_byte >= 8'h41 && i_byte <= 8'h46);
    assign hex_digit = c_digit ? i_byte[3:0] : i_byte[3:0] + 4'd9;
    assign grown = (r_len < LEN_CAP) ? r_len + LEN_W'(1) : r_len;

    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_start = r_start;
        n_len   = r_len;
        n_val   = r_val;
        n_bits  = r_bits;
        a_vld   = 1'b0;
        b_vld   = 1'b0;
        relex   = 1'b0;
        beg     = 1'b0;
        beg_num = 1'b0;
        beg_mode = M_IDLE;
        a_tok   = '0;
        a_tok.start = r_start;
        a_tok.len   = r_len;
        b_tok   = '0;
        b_tok.start = r_pos;
        b_tok.len   = LEN_W'(1);

        if (i_action) begin
            case (r_mode)
                M_SYM: begin
                    a_vld = 1'b1;
                    a_tok.kind = K_SYMBOL;
                end
                M_KEY: begin
                    a_vld = 1'b1;
                    a_tok.kind = K_KEYWORD;
                end
                M_NUM: begin
                    a_vld = 1'b1;
                    a_tok.kind  = K_NUMERAL;
                    a_tok.value = r_val;
                end
                M_BIN, M_HEX: begin
                    a_vld = 1'b1;
                    if (r_bits == '0) begin
                        a_tok.kind = K_ERROR;
                    end else begin
                        a_tok.kind  = K_BITVEC;
                        a_tok.value = r_val;
                        a_tok.width = r_bits;
                    end
                end
                M_STRQ: begin
                    a_vld = 1'b1;
                    a_tok.kind = K_STRING;
                end
                M_HASH, M_STR, M_QSYM: begin
                    a_vld = 1'b1;
                    a_tok.kind = K_ERROR;
                end
                default: begin
                    a_vld = 1'b0;
                end
            endcase
            b_vld      = 1'b1;
            b_tok.kind = K_EOF;
            b_tok.len  = '0;
            n_mode  = M_IDLE;
            n_pos   = '0;
            n_start = '0;
            n_len   = '0;
            n_val   = '0;
            n_bits  = '0;
        end else begin
            case (r_mode)
                M_COMMENT: begin
                    if (i_byte == CH_NL) begin
                        n_mode = M_IDLE;
                    end
                end
                M_SYM, M_KEY: begin
                    if (c_delim) begin
                        a_vld = 1'b1;
                        a_tok.kind = (r_mode == M_SYM) ? K_SYMBOL : K_KEYWORD;
                        relex = 1'b1;
                    end else begin
                        n_len = grown;
                    end
                end
                M_NUM: begin
                    if (c_digit) begin
                        n_len = grown;
                        n_val = (r_val << 3) + (r_val << 1) + VAL_W'(i_byte[3:0]);
                    end else begin
                        a_vld = 1'b1;
                        a_tok.kind  = K_NUMERAL;
                        a_tok.value = r_val;
                        relex = 1'b1;
                    end
                end
                M_HASH: begin
                    n_len = grown;
                    if (i_byte == 8'h62 || i_byte == 8'h42) begin
                        n_mode = M_BIN;
                    end else if (i_byte == 8'h78 || i_byte == 8'h58) begin
                        n_mode = M_HEX;
                    end else begin
                        a_vld = 1'b1;
                        a_tok.kind = K_ERROR;
                        a_tok.len  = grown;
                        n_mode = M_IDLE;
                    end
                end
                M_BIN, M_HEX: begin
                    if ((r_mode == M_BIN) ? (i_byte == 8'h30 || i_byte == 8'h31) : c_hex) begin
                        n_len = grown;
                        if (r_mode == M_BIN) begin
                            n_val  = {r_val[VAL_W-2:0], i_byte[0]};
                            n_bits = add_bits(r_bits, WID_W'(1));
                        end else begin
                            n_val  = {r_val[VAL_W-5:0], hex_digit};
                            n_bits = add_bits(r_bits, WID_W'(4));
                        end
                    end else begin
                        a_vld = 1'b1;
                        if (r_bits == '0) begin
                            a_tok.kind = K_ERROR;
                        end else begin
                            a_tok.kind  = K_BITVEC;
                            a_tok.value = r_val;
                            a_tok.width = r_bits;
                        end
                        relex = 1'b1;
                    end
                end
                M_STR: begin
                    n_len = grown;
                    if (i_byte == CH_DQ) begin
                        n_mode = M_STRQ;
                    end
                end
                M_STRQ: begin
                    if (i_byte == CH_DQ) begin
                        n_len  = grown;
                        n_mode = M_STR;
                    end else begin
                        a_vld = 1'b1;
                        a_tok.kind = K_STRING;
                        relex = 1'b1;
                    end
                end
                M_QSYM: begin
                    n_len = grown;
                    if (i_byte == CH_BAR) begin
                        a_vld = 1'b1;
                        a_tok.kind = K_SYMBOL;
                        a_tok.len  = grown;
                        n_mode = M_IDLE;
                    end
                end
                default: begin
                    relex = 1'b1;
                end
            endcase

            // Non-blank lookahead bytes that end a token, or idle bytes, open the next one.
            if (relex) begin
                n_mode = M_IDLE;
                if (!c_space) begin
                    case (i_byte)
                        CH_SEMI: n_mode = M_COMMENT;
                        CH_LPAR: begin
                            beg = 1'b1;
                            b_vld = 1'b1;
                            b_tok.kind = K_LPAREN;
                        end
                        CH_RPAR: begin
                            beg = 1'b1;
                            b_vld = 1'b1;
                            b_tok.kind = K_RPAREN;
                        end
                        CH_NUL: begin
                            beg = 1'b1;
                            b_vld = 1'b1;
                            b_tok.kind = K_ERROR;
                        end
                        CH_HASH: begin
                            beg = 1'b1;
                            beg_mode = M_HASH;
                        end
                        CH_DQ: begin
                            beg = 1'b1;
                            beg_mode = M_STR;
                        end
                        CH_COL: begin
                            beg = 1'b1;
                            beg_mode = M_KEY;
                        end
                        CH_BAR: begin
                            beg = 1'b1;
                            beg_mode = M_QSYM;
                        end
                        default: begin
                            beg = 1'b1;
                            beg_num = c_digit;
                            beg_mode = c_digit ? M_NUM : M_SYM;
                        end
                    endcase
                end
            end

            if (beg) begin
                n_mode  = beg_mode;
                n_start = r_pos;
                n_len   = LEN_W'(1);
                n_val   = beg_num ? VAL_W'(i_byte[3:0]) : '0;
                n_bits  = '0;
            end
            n_pos = r_pos + OFF_W'(1);
        end
    end

    assign o_push        = accept && (a_vld || b_vld);
    assign o_entry.two   = a_vld && b_vld;
    assign o_entry.tok0  = a_vld ? a_tok : b_tok;
    assign o_entry.tok1  = b_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_val   <= '0;
            r_bits  <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
            r_val   <= n_val;
            r_bits  <= n_bits;
        end
    end

    `SXL_ASSERT_NEXT(a_eof_rewinds, i_clk, i_rst_n, accept && i_action, r_mode == M_IDLE && r_pos == '0)
    `SXL_ASSERT_IMPL(a_eof_pushes_pair, i_clk, i_rst_n, accept && i_action, o_push && o_entry.tok1.kind == K_EOF)

endmodule

// ===== hw/rtl/sxl_queue.sv =====
// Short token queue between the lexer front end and the output stage.
`include "sexpr_token_lexer_assert.svh"
module sxl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sxl_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output sxl_pkg::t_entry o_head
);
    import sxl_pkg::*;

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr, r_rptr;
    logic [QCNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    `SXL_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= QCNT_W'(QDEPTH))
    `SXL_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + QCNT_W'(1))

endmodule

// ===== hw/rtl/sxl_back.sv =====
// Output stage: splits queued token pairs into single requests on the output stream.
`include "sexpr_token_lexer_assert.svh"
module sxl_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  sxl_pkg::t_entry i_head,
    input  logic            i_ready,
    output logic            o_pop,
    output logic            o_valid,
    output logic            o_last,
    output sxl_pkg::t_tok   o_tok
);
    import sxl_pkg::*;

    logic  r_sel;
    logic  r_valid;
    logic  r_last;
    t_tok  r_tok;
    logic  load, ends;

    assign load  = i_valid && (!r_valid || i_ready);
    assign ends  = r_sel || !i_head.two;
    assign o_pop = load && ends;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= !ends;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= r_sel ? i_head.tok1 : i_head.tok0;
            r_last <= ends;
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_tok   = r_tok;

    `SXL_ASSERT_IMPL(a_sel_needs_pair, i_clk, i_rst_n, r_sel, i_valid && i_head.two)
    `SXL_ASSERT_IMPL(a_first_of_pair, i_clk, i_rst_n, r_valid && !r_last, r_sel)

endmodule
